// ----- rtl/core/pfmd_pkg.sv -----
// Shared constants and types for the PID fader motor drive.
package pfmd_pkg;

    // Position width default
    localparam int POSITION_BITS_DEF = 10;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_SETTING = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY     = 3'd5;

    // Register widths
    localparam int CFG_DATA_W = 13;
    localparam int PGAIN_W    = 12;
    localparam int IGAIN_W    = 12;
    localparam int DGAIN_W    = 13;
    localparam int GSET_W     = 7;
    localparam int LIMIT_W    = 10;
    localparam int DUTY_W     = 10;

    // Register reset values
    localparam logic [PGAIN_W-1:0] PGAIN_RST  = 12'd1000;
    localparam logic [IGAIN_W-1:0] IGAIN_RST  = 12'd1;
    localparam logic [DGAIN_W-1:0] DGAIN_RST  = 13'd4000;
    localparam logic [GSET_W-1:0]  GSET_RST   = 7'd75;
    localparam logic [LIMIT_W-1:0] LIMIT_RST  = 10'd500;
    localparam logic [DUTY_W-1:0]  DUTY_RST   = 10'd1023;

    // Divisor is DIV_BASE minus the gain setting, setting capped at GAIN_MAX
    localparam logic [GSET_W-1:0] DIV_BASE = 7'd101;
    localparam logic [GSET_W-1:0] GAIN_MAX = 7'd100;

    // Three PID terms share one multiplier
    localparam int NUM_TERMS = 3;

    // Integral storage: limit magnitude plus sign
    localparam int INTEG_W = LIMIT_W + 1;

    // Widest gain width; zero-extended into the signed multiplier operand
    localparam int COEF_W = DGAIN_W;

    // Result fields, lowest bit first
    localparam int SPEED_W    = 26;
    localparam int OUT_DOWN_LO  = 0;
    localparam int OUT_UP_LO    = OUT_DOWN_LO + DUTY_W;
    localparam int OUT_EN_BIT   = OUT_UP_LO + DUTY_W;
    localparam int OUT_SPEED_LO = OUT_EN_BIT + 1;
    localparam int OUT_FIELDS_W = OUT_SPEED_LO + SPEED_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ----- rtl/core/pfmd_div.sv -----
// Bit-serial restoring divider: unsigned dividend by a 7-bit divisor.
module pfmd_div #(
    parameter int WIDTH = 27
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [WIDTH-1:0]              i_dividend,
    input  logic [pfmd_pkg::GSET_W-1:0]   i_divisor,
    output pfmd_pkg::t_div_stat           o_stat,
    output logic [WIDTH-1:0]              o_quot
);

    localparam int CNT_W = $clog2(WIDTH + 1);
    localparam int DV_W  = pfmd_pkg::GSET_W;

    logic [WIDTH-1:0] r_q;
    logic [DV_W-1:0]  r_rem;
    logic [DV_W-1:0]  r_d;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DV_W:0]    trial;
    logic             ge;
    logic [DV_W:0]    diff;

    // One quotient bit per cycle
    always_comb begin
        trial = {r_rem, r_q[WIDTH-1]};
        ge    = (trial >= {1'b0, r_d});
        diff  = trial - {1'b0, r_d};
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(WIDTH - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend shifts out the top while quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[WIDTH-2:0], ge};
            r_rem <= ge ? diff[DV_W-1:0] : trial[DV_W-1:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_q;

endmodule

// ----- rtl/core/pid_fader_motor_drive.sv -----
// PID fader motor drive: error terms, shared MAC, serial divide, duty drive.
//
//  channel | dir | handshake                         | contents
//  s_axis  | in  | s_axis_tvalid / s_axis_tready     | goal, position, gating flags
//  m_axis  | out | m_axis_tvalid / m_axis_tready     | duties, enable, speed
//  cfg     | in  | i_cfg_we (no wait)                | i_cfg_idx, i_cfg_data
//
// Each item, after its transfer, passes the shared multiplier for the three
// terms with the product registered before the add, then a divider load, the
// divider steps (one quotient bit each), the divider done flag and the forming
// of the result. The bit-serial divider dominates; the sequencer is back in
// idle as the result is registered, and the next transfer can follow then.
// s_axis_tready is high only while the sequencer is idle; a result waits in
// the output register and the next item is taken meanwhile. Reset is
// synchronous, clears the integral and previous error and reloads the config
// defaults.
module pid_fader_motor_drive #(
    parameter int POSITION_BITS = pfmd_pkg::POSITION_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // tdata: goal, position, fader_ready, local_touch, host_motors_off,
    //        settle_expired, zero fill
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((2*POSITION_BITS+4+7)/8)*8-1:0] s_axis_tdata,
    // tdata: duty_down, duty_up, motor_enable, speed, zero fill
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [pfmd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [pfmd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pfmd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int PB     = POSITION_BITS;
    localparam int ERR_W  = PB + 1;
    localparam int DERR_W = PB + 2;
    localparam int IW     = pfmd_pkg::INTEG_W;
    localparam int ISUM_W = ((ERR_W > IW) ? ERR_W : IW) + 1;
    localparam int OP_W   = (DERR_W > IW) ? DERR_W : IW;
    localparam int PROD_W = pfmd_pkg::COEF_W + 1 + OP_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int STEP_W = $clog2(pfmd_pkg::NUM_TERMS + 1);
    localparam int SW     = pfmd_pkg::SPEED_W;
    localparam int DW     = pfmd_pkg::DUTY_W;

    localparam logic [SUM_W-1:0] MAG_POS_MAX = SUM_W'((64'd1 << (SW - 1)) - 64'd1);
    localparam logic [SUM_W-1:0] MAG_NEG_MAX = SUM_W'(64'd1 << (SW - 1));
    localparam logic [SUM_W-1:0] DEADBAND    = SUM_W'(1);

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MAC   = 3'd1;
    localparam logic [2:0] ST_DLOAD = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    // ---------------- configuration registers ----------------
    logic [pfmd_pkg::PGAIN_W-1:0] r_prop_gain;
    logic [pfmd_pkg::IGAIN_W-1:0] r_integ_gain;
    logic [pfmd_pkg::DGAIN_W-1:0] r_deriv_gain;
    logic [pfmd_pkg::GSET_W-1:0]  r_gain_setting;
    logic [pfmd_pkg::LIMIT_W-1:0] r_integ_limit;
    logic [pfmd_pkg::DUTY_W-1:0]  r_max_duty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain    <= pfmd_pkg::PGAIN_RST;
            r_integ_gain   <= pfmd_pkg::IGAIN_RST;
            r_deriv_gain   <= pfmd_pkg::DGAIN_RST;
            r_gain_setting <= pfmd_pkg::GSET_RST;
            r_integ_limit  <= pfmd_pkg::LIMIT_RST;
            r_max_duty     <= pfmd_pkg::DUTY_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pfmd_pkg::REG_PROP_GAIN:
                    r_prop_gain <= i_cfg_data[pfmd_pkg::PGAIN_W-1:0];
                pfmd_pkg::REG_INTEG_GAIN:
                    r_integ_gain <= i_cfg_data[pfmd_pkg::IGAIN_W-1:0];
                pfmd_pkg::REG_DERIV_GAIN:
                    r_deriv_gain <= i_cfg_data[pfmd_pkg::DGAIN_W-1:0];
                pfmd_pkg::REG_GAIN_SETTING:
                    r_gain_setting <= i_cfg_data[pfmd_pkg::GSET_W-1:0];
                pfmd_pkg::REG_INTEG_LIMIT:
                    r_integ_limit <= i_cfg_data[pfmd_pkg::LIMIT_W-1:0];
                pfmd_pkg::REG_MAX_DUTY:
                    r_max_duty <= i_cfg_data[pfmd_pkg::DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- input unpacking ----------------
    logic [PB-1:0] in_goal;
    logic [PB-1:0] in_pos;
    logic          in_ready;
    logic          in_touch;
    logic          in_host_off;
    logic          in_settled;

    assign in_goal     = s_axis_tdata[PB-1:0];
    assign in_pos      = s_axis_tdata[2*PB-1:PB];
    assign in_ready    = s_axis_tdata[2*PB];
    assign in_touch    = s_axis_tdata[2*PB+1];
    assign in_host_off = s_axis_tdata[2*PB+2];
    assign in_settled  = s_axis_tdata[2*PB+3];

    // ---------------- sequencer and state ----------------
    logic [2:0]              r_state;
    logic [2:0]              n_state;
    logic [STEP_W-1:0]       r_step;
    logic signed [ERR_W-1:0] r_prev_err;
    logic signed [IW-1:0]    r_integ;
    logic signed [ERR_W-1:0] r_err;
    logic signed [DERR_W-1:0] r_derr;
    logic                    r_allow;
    logic [pfmd_pkg::GSET_W-1:0] r_divisor;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [SUM_W-1:0]  r_acc;
    logic                    r_neg;
    logic                    r_out_valid;
    logic [pfmd_pkg::OUT_TDATA_W-1:0] r_out_data;

    logic                    in_xfer;
    logic                    out_free;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    pfmd_pkg::t_div_stat     div_stat;
    logic [SUM_W-1:0]        div_quot;
    logic [SUM_W-1:0]        acc_mag;

    // Error, clamped integral and error change, formed at the transfer
    logic signed [ERR_W-1:0]  err;
    logic signed [ISUM_W-1:0] isum;
    logic signed [ISUM_W-1:0] ilim;
    logic signed [IW-1:0]     integ_next;
    logic signed [DERR_W-1:0] derr;
    logic [pfmd_pkg::GSET_W-1:0] gain_cap;

    always_comb begin
        err  = $signed({1'b0, in_goal}) - $signed({1'b0, in_pos});
        isum = ISUM_W'(r_integ) + ISUM_W'(err);
        ilim = $signed(ISUM_W'({1'b0, r_integ_limit}));
        if (isum > ilim) begin
            integ_next = IW'(ilim);
        end else if (isum < -ilim) begin
            integ_next = IW'(-ilim);
        end else begin
            integ_next = IW'(isum);
        end
        derr     = DERR_W'(err) - DERR_W'(r_prev_err);
        gain_cap = (r_gain_setting > pfmd_pkg::GAIN_MAX) ? pfmd_pkg::GAIN_MAX
                                                         : r_gain_setting;
    end

    // Shared multiplier operand select
    logic [pfmd_pkg::COEF_W-1:0] mul_coef;
    logic signed [OP_W-1:0]      mul_op;
    logic signed [PROD_W-1:0]    mul_out;

    always_comb begin
        case (r_step)
            STEP_W'(0): begin
                mul_coef = pfmd_pkg::COEF_W'(r_prop_gain);
                mul_op   = OP_W'(r_err);
            end
            STEP_W'(1): begin
                mul_coef = pfmd_pkg::COEF_W'(r_integ_gain);
                mul_op   = OP_W'(r_integ);
            end
            STEP_W'(2): begin
                mul_coef = r_deriv_gain;
                mul_op   = OP_W'(r_derr);
            end
            default: begin
                mul_coef = '0;
                mul_op   = '0;
            end
        endcase
        mul_out = $signed({1'b0, mul_coef}) * mul_op;
    end

    // Next-state logic
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (in_xfer) n_state = ST_MAC;
            ST_MAC:   if (r_step == STEP_W'(pfmd_pkg::NUM_TERMS)) n_state = ST_DLOAD;
            ST_DLOAD: n_state = ST_DIV;
            ST_DIV:   if (div_stat.done) n_state = ST_FIN;
            ST_FIN:   if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_step     <= '0;
            r_prev_err <= '0;
            r_integ    <= '0;
        end else begin
            r_state <= n_state;
            if (in_xfer) begin
                r_prev_err <= err;
                r_integ    <= integ_next;
                r_step     <= '0;
            end else if (r_state == ST_MAC) begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    // Item payload and multiply-accumulate; product registered before the add
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_err     <= err;
            r_derr    <= derr;
            r_allow   <= !in_ready || (!in_touch && !in_host_off && !in_settled);
            r_divisor <= pfmd_pkg::DIV_BASE - gain_cap;
            r_acc     <= '0;
        end else if (r_state == ST_MAC) begin
            r_prod <= mul_out;
            if (r_step != '0) begin
                r_acc <= r_acc + SUM_W'(r_prod);
            end
        end
        if (r_state == ST_DLOAD) begin
            r_neg <= r_acc[SUM_W-1];
        end
    end

    // Magnitude of the sum; the divider truncates it, sign goes back after
    assign acc_mag = r_acc[SUM_W-1] ? SUM_W'(-r_acc) : SUM_W'(r_acc);

    pfmd_div #(
        .WIDTH (SUM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == ST_DLOAD),
        .i_dividend (acc_mag),
        .i_divisor  (r_divisor),
        .o_stat     (div_stat),
        .o_quot     (div_quot)
    );

    // Saturate, deadband and duty drive
    logic [SUM_W-1:0] mag_sat;
    logic [SW-1:0]    speed;
    logic             active;
    logic [DW-1:0]    duty;
    logic [DW-1:0]    duty_down;
    logic [DW-1:0]    duty_up;

    always_comb begin
        if (r_neg) begin
            mag_sat = (div_quot > MAG_NEG_MAX) ? MAG_NEG_MAX : div_quot;
        end else begin
            mag_sat = (div_quot > MAG_POS_MAX) ? MAG_POS_MAX : div_quot;
        end
        speed     = r_neg ? SW'(-mag_sat) : SW'(mag_sat);
        active    = r_allow && (mag_sat > DEADBAND);
        duty      = (mag_sat > SUM_W'(r_max_duty)) ? r_max_duty : mag_sat[DW-1:0];
        duty_down = (active && r_neg)  ? duty : '0;
        duty_up   = (active && !r_neg) ? duty : '0;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_FIN && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN && out_free) begin
            r_out_data <= pfmd_pkg::OUT_TDATA_W'({speed, active, duty_up, duty_down});
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ----- rtl/core/pfmd_chk.sv -----
// Port-level assertions for the PID fader motor drive, bound to the top level.
module pfmd_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [pfmd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    localparam int DW = pfmd_pkg::DUTY_W;

    logic [DW-1:0] o_down;
    logic [DW-1:0] o_up;
    logic          o_en;

    assign o_down = m_axis_tdata[pfmd_pkg::OUT_DOWN_LO +: DW];
    assign o_up   = m_axis_tdata[pfmd_pkg::OUT_UP_LO +: DW];
    assign o_en   = m_axis_tdata[pfmd_pkg::OUT_EN_BIT];

    // A held result stays put until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // One item at a time: busy right after an input transfer
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in work");

    // No result can appear the cycle after an input transfer
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result appeared too early");

    // Duties are zero when the motor is off, and never both driven
    a_duty_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((o_en || (o_down == '0 && o_up == '0))
                           && (o_down == '0 || o_up == '0)))
        else $error("inconsistent duty outputs");

    // Reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind pid_fader_motor_drive pfmd_chk u_pfmd_chk (.*);
